@@ rtl/cvm_pkg.sv @@
// ----------------------------------------------------------------------------
// cvm_pkg
// Shared constants, types and register codes of the cell voltage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package cvm_pkg;

  localparam int PACK_COUNT     = 2;
  localparam int CELLS_PER_PACK = 16;
  localparam int WINDOW_DEPTH   = 8;

  localparam int TOTAL_CELLS = PACK_COUNT * CELLS_PER_PACK;
  localparam int RING_DEPTH  = TOTAL_CELLS * WINDOW_DEPTH;

  localparam int PACK_W   = 1;
  localparam int CELL_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int BYTE_W   = 8;
  localparam int CELL_AW  = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1;
  localparam int RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W    = SAMPLE_W + 1 + $clog2(WINDOW_DEPTH);
  localparam int CMP_W    = SAMPLE_W + 2 + CNT_W;
  localparam int STEP_W   = $clog2(SUM_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = 16'sd22133;
  localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = 16'sd16000;

  // flag values of a cell whose average is zero, under the reset thresholds
  localparam logic OVER_RESET_BIT    = (UPPER_RESET < 0);
  localparam logic UNDER_RESET_BIT   = (LOWER_RESET > 0);
  localparam logic BALANCE_RESET_BIT = (UPPER_RESET <= 0);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_STATE_RD = 6'b000010,
    ST_RING_RD = 6'b000100,
    ST_UPDATE  = 6'b001000,
    ST_DIV     = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic [PTR_W-1:0]        ptr;
  } cell_entry_t;

endpackage

`default_nettype wire

@@ rtl/cvm_in_if.sv @@
// ----------------------------------------------------------------------------
// cvm_in_if
// Sample request channel: pack, cell and converter code.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvm_in_if import cvm_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic [PACK_W-1:0]          pack_index;
  logic [CELL_W-1:0]          cell_index;
  logic signed [SAMPLE_W-1:0] sample_code;

  modport source (output valid, output pack_index, output cell_index, output sample_code,
                  input ready);
  modport sink   (input valid, input pack_index, input cell_index, input sample_code,
                  output ready);

endinterface

`default_nettype wire

@@ rtl/cvm_out_if.sv @@
// ----------------------------------------------------------------------------
// cvm_out_if
// Result request channel: cell average, summary flags and balance bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvm_out_if import cvm_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] avg_code;
  logic                       any_over;
  logic                       any_under;
  logic                       any_balancing;
  logic [BYTE_W-1:0]          balance_first_byte;
  logic [BYTE_W-1:0]          balance_second_byte;

  modport source (output valid, output avg_code, output any_over, output any_under,
                  output any_balancing, output balance_first_byte,
                  output balance_second_byte, input ready);
  modport sink   (input valid, input avg_code, input any_over, input any_under,
                  input any_balancing, input balance_first_byte,
                  input balance_second_byte, output ready);

endinterface

`default_nettype wire

@@ rtl/cvm_ram.sv @@
// ----------------------------------------------------------------------------
// cvm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/cell_voltage_monitor.sv @@
// ----------------------------------------------------------------------------
// cell_voltage_monitor
// Moving-average over/under-voltage and balance monitor for battery cells.
// ----------------------------------------------------------------------------
// Each sample request carries a pack, a cell and a signed converter code. The
// code enters that cell's ring of the last WINDOW_DEPTH samples; the running
// sum and fill count live in a per-cell state RAM, the samples in a ring RAM.
// One result request follows each sample: the truncated average of the held
// samples, the any-over/under/balancing summary over all cells and the
// sampled pack's balance bytes. An in-range sample goes through state read,
// ring read and update, then the bit-serial divider that forms the average;
// an out-of-range sample goes straight to done. Threshold writes apply to
// a cell from its next sample on. No clearing pass: per-cell state has valid
// bits, and ring entries are only used once written.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_voltage_monitor import cvm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cvm_in_if.sink                req_i,
  cvm_out_if.source             res_o
);

  state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] upper_q, lower_q;
  logic [TOTAL_CELLS-1:0]     over_q, under_q, balance_q, entry_vld_q;

  logic [PACK_W-1:0]          pack_q;
  logic [CELL_AW-1:0]         idx_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       skip_q;
  cell_entry_t                entry_q;
  logic [RING_AW-1:0]         ring_addr_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]           cnt_q;

  logic [CNT_W-1:0]           rem_q;
  logic [SUM_W-1:0]           quo_q;
  logic [STEP_W-1:0]          step_q;
  logic                       neg_q;

  logic                       res_valid_q;
  logic signed [SAMPLE_W-1:0] res_avg_q;
  logic                       res_over_q, res_under_q, res_bal_q;
  logic [BYTE_W-1:0]          res_b1_q, res_b2_q;

  // ---------------------------------------------------------------- request
  logic               accept, in_range;
  logic [CELL_AW-1:0] in_idx;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = (int'(req_i.pack_index) < PACK_COUNT) &&
                       (int'(req_i.cell_index) < CELLS_PER_PACK);
  assign in_idx      = CELL_AW'(int'(req_i.pack_index) * CELLS_PER_PACK +
                                int'(req_i.cell_index));

  // --------------------------------------------------------------- memories
  logic                      st_re, st_we;
  logic [$bits(cell_entry_t)-1:0] st_rdata;
  cell_entry_t               st_rentry, st_wentry;
  logic                      ring_re, ring_we;
  logic [RING_AW-1:0]        ring_raddr;
  logic [SAMPLE_W-1:0]       ring_rdata;
  logic [PTR_W-1:0]          ptr_cur, ptr_next;

  assign st_re     = accept && in_range;
  assign st_rentry = entry_vld_q[idx_q] ? cell_entry_t'(st_rdata) : '0;
  assign ptr_cur   = (int'(st_rentry.ptr) >= WINDOW_DEPTH) ? '0 : st_rentry.ptr;
  assign ring_re   = (state_q == ST_STATE_RD);
  assign ring_raddr = RING_AW'(int'(idx_q) * WINDOW_DEPTH + int'(ptr_cur));

  cvm_ram #(
    .WIDTH ($bits(cell_entry_t)),
    .DEPTH (TOTAL_CELLS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (idx_q),
    .wdata_i (st_wentry),
    .re_i    (st_re),
    .raddr_i (in_idx),
    .rdata_o (st_rdata)
  );

  cvm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_addr_q),
    .wdata_i (sample_q),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // ----------------------------------------------------- sum and write-back
  logic                    full;
  logic signed [SUM_W-1:0] old_ext, sum_new;
  logic [CNT_W-1:0]        cnt_new;

  assign full     = (int'(entry_q.count) >= WINDOW_DEPTH);
  assign old_ext  = full ? SUM_W'($signed(ring_rdata)) : SUM_W'(0);
  assign sum_new  = entry_q.sum + SUM_W'(sample_q) - old_ext;
  assign cnt_new  = full ? entry_q.count : entry_q.count + CNT_W'(1);
  assign ptr_next = (int'(entry_q.ptr) == WINDOW_DEPTH - 1) ? '0 : entry_q.ptr + PTR_W'(1);

  assign st_we   = (state_q == ST_RING_RD);
  assign ring_we = (state_q == ST_RING_RD);
  always_comb begin
    st_wentry.sum   = sum_new;
    st_wentry.count = cnt_new;
    st_wentry.ptr   = ptr_next;
  end

  // ------------------------------------------------------------ flag update
  logic signed [CMP_W-1:0] sum_ext, cnt_ext, up_ext, lo_ext, up_lim, lo_lim;

  always_comb begin
    sum_ext = CMP_W'(sum_q);
    cnt_ext = CMP_W'($signed({1'b0, cnt_q}));
    up_ext  = CMP_W'(upper_q);
    lo_ext  = CMP_W'(lower_q);
    up_lim  = CMP_W'(up_ext * cnt_ext);
    lo_lim  = CMP_W'(lo_ext * cnt_ext);
  end

  // ---------------------------------------------------------------- divider
  logic [CNT_W:0]   rem_sh;
  logic             div_ge;
  logic [SUM_W-1:0] quo_signed;

  assign rem_sh     = {rem_q, quo_q[SUM_W-1]};
  assign div_ge     = (rem_sh >= {1'b0, cnt_q});
  assign quo_signed = neg_q ? (SUM_W'(0) - quo_q) : quo_q;

  // ---------------------------------------------------------- result fields
  logic [BYTE_W-1:0] byte1, byte2;
  logic              res_load;

  always_comb begin
    byte1 = '0;
    byte2 = '0;
    for (int j = 0; j < 2 * BYTE_W; j++) begin
      if (!skip_q && j < CELLS_PER_PACK) begin
        if (j < BYTE_W) begin
          byte1[BYTE_W-1-j] = balance_q[CELL_AW'(int'(pack_q) * CELLS_PER_PACK + j)];
        end else begin
          byte2[2*BYTE_W-1-j] = balance_q[CELL_AW'(int'(pack_q) * CELLS_PER_PACK + j)];
        end
      end
    end
  end

  assign res_load = (state_q == ST_DONE) && (!res_valid_q || res_o.ready);

  // ------------------------------------------------------------------- fsm
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = in_range ? ST_STATE_RD : ST_DONE;
        end
      end
      ST_STATE_RD: state_d = ST_RING_RD;
      ST_RING_RD:  state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upper_q     <= UPPER_RESET;
      lower_q     <= LOWER_RESET;
      over_q      <= {TOTAL_CELLS{OVER_RESET_BIT}};
      under_q     <= {TOTAL_CELLS{UNDER_RESET_BIT}};
      balance_q   <= {TOTAL_CELLS{BALANCE_RESET_BIT}};
      entry_vld_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_UPPER: upper_q <= $signed(cfg_data_i[SAMPLE_W-1:0]);
          REG_LOWER: lower_q <= $signed(cfg_data_i[SAMPLE_W-1:0]);
          default: ;
        endcase
      end
      if (st_we) begin
        entry_vld_q[idx_q] <= 1'b1;
      end
      if (state_q == ST_UPDATE) begin
        over_q[idx_q]    <= (sum_ext > up_lim);
        under_q[idx_q]   <= (sum_ext < lo_lim);
        balance_q[idx_q] <= (sum_ext >= up_lim);
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pack_q   <= req_i.pack_index;
      idx_q    <= in_idx;
      sample_q <= req_i.sample_code;
      skip_q   <= !in_range;
    end
    if (state_q == ST_STATE_RD) begin
      entry_q.sum   <= st_rentry.sum;
      entry_q.count <= st_rentry.count;
      entry_q.ptr   <= ptr_cur;
      ring_addr_q   <= ring_raddr;
    end
    if (state_q == ST_RING_RD) begin
      sum_q <= sum_new;
      cnt_q <= cnt_new;
    end
    if (state_q == ST_UPDATE) begin
      neg_q  <= sum_q[SUM_W-1];
      quo_q  <= sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
      rem_q  <= '0;
      step_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q  <= CNT_W'(div_ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh);
      quo_q  <= {quo_q[SUM_W-2:0], div_ge};
      step_q <= step_q + STEP_W'(1);
    end
    if (res_load) begin
      res_avg_q   <= skip_q ? '0 : $signed(quo_signed[SAMPLE_W-1:0]);
      res_over_q  <= |over_q;
      res_under_q <= |under_q;
      res_bal_q   <= |balance_q;
      res_b1_q    <= byte1;
      res_b2_q    <= byte2;
    end
  end

  assign res_o.valid               = res_valid_q;
  assign res_o.avg_code            = res_avg_q;
  assign res_o.any_over            = res_over_q;
  assign res_o.any_under           = res_under_q;
  assign res_o.any_balancing       = res_bal_q;
  assign res_o.balance_first_byte  = res_b1_q;
  assign res_o.balance_second_byte = res_b2_q;

  // ------------------------------------------------------------- assertions
  a_div_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0))
    else $error("divider running with zero fill count");

  a_writeback_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (st_wentry.count != '0 && int'(st_wentry.count) <= WINDOW_DEPTH &&
               int'(st_wentry.ptr) < WINDOW_DEPTH))
    else $error("cell entry written back out of range");

  a_skip_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_range) |=> (state_q == ST_DONE && skip_q))
    else $error("out-of-range sample did not bypass the datapath");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Regression for the cell voltage monitor. Sample requests go in through
// randomly gapped handshakes. An internal moving-average predictor works out
// each result request. A scoreboard checks every accepted result, field by
// field, in order. The run covers several threshold settings, three idling
// profiles and one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import cvm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SEG_ITEMS    = 330;
  localparam int HOLD_CYCLES  = 600;

  typedef struct {
    logic signed [SAMPLE_W-1:0] avg_code;
    logic                       any_over;
    logic                       any_under;
    logic                       any_balancing;
    logic [BYTE_W-1:0]          balance_first_byte;
    logic [BYTE_W-1:0]          balance_second_byte;
  } monitor_result_t;

  typedef enum int {
    CODE_NEAR_UPPER,
    CODE_NEAR_LOWER,
    CODE_ANY,
    CODE_EXTREME
  } code_kind_e;

  class cell_monitor_scoreboard;
    logic signed [SAMPLE_W-1:0] sample_hist [TOTAL_CELLS][WINDOW_DEPTH];
    longint window_sum [TOTAL_CELLS];
    int     held_count [TOTAL_CELLS];
    int     next_slot  [TOTAL_CELLS];
    bit     over_flag  [TOTAL_CELLS];
    bit     under_flag [TOTAL_CELLS];
    bit     bal_flag   [TOTAL_CELLS];
    int     upper_limit;
    int     lower_limit;
    monitor_result_t expected_results [$];
    int     errors;

    function new();
      upper_limit = UPPER_RESET;
      lower_limit = LOWER_RESET;
      errors = 0;
      for (int k = 0; k < TOTAL_CELLS; k++) begin
        window_sum[k] = 0;
        held_count[k] = 0;
        next_slot[k]  = 0;
        over_flag[k]  = (0 > upper_limit);
        under_flag[k] = (0 < lower_limit);
        bal_flag[k]   = (0 >= upper_limit);
      end
    endfunction

    function void set_threshold(cfg_reg_e idx, logic signed [CFG_DATA_W-1:0] val);
      if (idx == REG_UPPER) upper_limit = val;
      else if (idx == REG_LOWER) lower_limit = val;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_sample(logic [PACK_W-1:0] pack, logic [CELL_W-1:0] cell_sel,
                              logic signed [SAMPLE_W-1:0] code);
      monitor_result_t r;
      int     idx;
      int     slot;
      longint cnt;
      r.avg_code            = '0;
      r.balance_first_byte  = '0;
      r.balance_second_byte = '0;
      if (int'(pack) < PACK_COUNT && int'(cell_sel) < CELLS_PER_PACK) begin
        idx  = int'(pack) * CELLS_PER_PACK + int'(cell_sel);
        slot = next_slot[idx];
        if (held_count[idx] < WINDOW_DEPTH) begin
          held_count[idx]++;
          window_sum[idx] += longint'(code);
        end else begin
          window_sum[idx] += longint'(code) - longint'(sample_hist[idx][slot]);
        end
        sample_hist[idx][slot] = code;
        next_slot[idx] = (slot + 1) % WINDOW_DEPTH;
        cnt = held_count[idx];
        r.avg_code      = SAMPLE_W'(window_sum[idx] / cnt);
        over_flag[idx]  = window_sum[idx] >  longint'(upper_limit) * cnt;
        under_flag[idx] = window_sum[idx] <  longint'(lower_limit) * cnt;
        bal_flag[idx]   = window_sum[idx] >= longint'(upper_limit) * cnt;
        for (int j = 0; j < CELLS_PER_PACK; j++) begin
          if (bal_flag[int'(pack) * CELLS_PER_PACK + j]) begin
            if (j < 8) r.balance_first_byte[7 - j] = 1'b1;
            else r.balance_second_byte[15 - j] = 1'b1;
          end
        end
      end
      r.any_over      = 1'b0;
      r.any_under     = 1'b0;
      r.any_balancing = 1'b0;
      for (int k = 0; k < TOTAL_CELLS; k++) begin
        r.any_over      |= over_flag[k];
        r.any_under     |= under_flag[k];
        r.any_balancing |= bal_flag[k];
      end
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, int want, int got);
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
      errors++;
    endtask

    task check_result(monitor_result_t got);
      monitor_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result request with nothing pending", 0, 1);
        return;
      end
      want = expected_results.pop_front();
      if (got.avg_code !== want.avg_code)
        report_mismatch("avg_code", want.avg_code, got.avg_code);
      if (got.any_over !== want.any_over)
        report_mismatch("any_over", want.any_over, got.any_over);
      if (got.any_under !== want.any_under)
        report_mismatch("any_under", want.any_under, got.any_under);
      if (got.any_balancing !== want.any_balancing)
        report_mismatch("any_balancing", want.any_balancing, got.any_balancing);
      if (got.balance_first_byte !== want.balance_first_byte)
        report_mismatch("balance_first_byte", want.balance_first_byte,
                        got.balance_first_byte);
      if (got.balance_second_byte !== want.balance_second_byte)
        report_mismatch("balance_second_byte", want.balance_second_byte,
                        got.balance_second_byte);
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cvm_in_if  req_if ();
  cvm_out_if res_if ();

  cell_voltage_monitor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  cell_monitor_scoreboard sb;
  monitor_result_t        seen_result;
  int                     tx_idle_pct;
  int                     rx_idle_pct;
  int                     hold_request;
  int                     cycle_count;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cell_voltage_monitor regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      sb.note_sample(req_if.pack_index, req_if.cell_index, req_if.sample_code);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_result.avg_code            = res_if.avg_code;
      seen_result.any_over            = res_if.any_over;
      seen_result.any_under           = res_if.any_under;
      seen_result.any_balancing       = res_if.any_balancing;
      seen_result.balance_first_byte  = res_if.balance_first_byte;
      seen_result.balance_second_byte = res_if.balance_second_byte;
      sb.check_result(seen_result);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_request) @(negedge clk_i);
        hold_request = 0;
      end
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_code(code_kind_e kind);
    int v;
    case (kind)
      CODE_NEAR_UPPER: v = sb.upper_limit + int'($urandom_range(8)) - 4;
      CODE_NEAR_LOWER: v = sb.lower_limit + int'($urandom_range(8)) - 4;
      CODE_EXTREME: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  task automatic send_sample(logic [PACK_W-1:0] pack, logic [CELL_W-1:0] cell_sel,
                             logic signed [SAMPLE_W-1:0] code);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.pack_index  <= pack;
    req_if.cell_index  <= cell_sel;
    req_if.sample_code <= code;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(idx, val);
  endtask

  task automatic run_segment(int n_items);
    int sent;
    int burst;
    logic [PACK_W-1:0] pack;
    logic [CELL_W-1:0] cell_sel;
    code_kind_e kind;
    sent = 0;
    while (sent < n_items) begin
      pack     = PACK_W'($urandom_range(1));
      cell_sel = CELL_W'($urandom_range(15));
      burst    = $urandom_range(12, 1);
      kind     = code_kind_e'($urandom_range(3));
      for (int k = 0; k < burst && sent < n_items; k++) begin
        if ($urandom_range(9) == 0)
          send_sample(PACK_W'($urandom_range(1)), CELL_W'($urandom_range(15)),
                      pick_code(CODE_ANY));
        else
          send_sample(pack, cell_sel, pick_code(kind));
        sent++;
      end
    end
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_UPPER;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.pack_index  = '0;
    req_if.cell_index  = '0;
    req_if.sample_code = '0;
    res_if.ready       = 1'b0;
    tx_idle_pct        = 7;
    rx_idle_pct        = 61;
    hold_request       = 0;
    cycle_count        = 0;
    sb = new();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: ring wrap at both code extremes, exact limit hits
    repeat (9) send_sample(1'b0, 4'd0, -16'sd32768);
    repeat (9) send_sample(1'b1, 4'd15, 16'sd32767);
    send_sample(1'b0, 4'd7, 16'sd22133);
    send_sample(1'b0, 4'd8, 16'sd22134);
    send_sample(1'b1, 4'd0, 16'sd15999);
    send_sample(1'b1, 4'd8, 16'sd16000);
    send_sample(1'b0, 4'd15, 16'sd0);

    for (int seg = 0; seg < 6; seg++) begin
      wait_idle();
      tx_idle_pct = (seg < 2) ? 7 : (seg < 4) ? 61 : 0;
      rx_idle_pct = (seg < 2) ? 61 : (seg < 4) ? 7 : 0;
      case (seg)
        1: begin
          write_reg(REG_UPPER, 16'h7FFF);
          write_reg(REG_LOWER, 16'h8000);
          hold_request = HOLD_CYCLES;
        end
        2: begin
          write_reg(REG_UPPER, 16'h8000);
          write_reg(REG_LOWER, 16'h7FFF);
        end
        3: begin
          write_reg(REG_UPPER, CFG_DATA_W'($urandom_range(65535)));
          write_reg(REG_LOWER, CFG_DATA_W'($urandom_range(65535)));
        end
        4: begin
          write_reg(REG_UPPER, '0);
          write_reg(REG_LOWER, '0);
        end
        5: begin
          write_reg(REG_UPPER, CFG_DATA_W'(int'($urandom_range(4000)) - 2000));
          write_reg(REG_LOWER, CFG_DATA_W'(int'($urandom_range(4000)) - 2000));
        end
        default: ;
      endcase
      run_segment(SEG_ITEMS);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("cell_voltage_monitor regression: pass");
    end else begin
      $display("cell_voltage_monitor regression: fail");
    end
    $finish;
  end

endmodule
